@@ hdl/rgb_pixel_pulse_encoder_macros.svh @@
// ============================================================================
// rgb_pixel_pulse_encoder_macros : assertion macros
// Shared concurrent assertion forms for the pixel encoder checkers.
// ============================================================================
`ifndef RGB_PIXEL_PULSE_ENCODER_MACROS_SVH
`define RGB_PIXEL_PULSE_ENCODER_MACROS_SVH

// clocked property, ignored while reset is asserted
`define RPPE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rppe assertion failed");

// same, with a message of the caller's choice
`define RPPE_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

@@ hdl/rppe_pkg.sv @@
// ============================================================================
// rppe_pkg : pixel pulse encoder package
// Widths, register map, reset values and the divide-by-255 helper.
// ============================================================================
package rppe_pkg;

    localparam int BYTE_W        = 8;
    localparam int SLOT_W        = 2;
    localparam int TICK_W        = 8;
    localparam int LED_W         = 4;
    localparam int BITNUM_W      = 5;
    localparam int BITS_PER_PIXEL = 24;
    localparam int PROD_W        = 2 * BYTE_W;
    localparam int ADDR_W        = 5;
    localparam int DATA_W        = 32;

    localparam logic [BITNUM_W-1:0] LAST_BIT_NUM = BITNUM_W'(BITS_PER_PIXEL - 1);

    // byte slots in the 24-bit word, slot 0 is sent first
    localparam logic [SLOT_W-1:0] SLOT_HI   = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_MID  = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_LO   = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_RED_SLOT   = 3'd0;
    localparam logic [2:0] REG_GREEN_SLOT = 3'd1;
    localparam logic [2:0] REG_BLUE_SLOT  = 3'd2;
    localparam logic [2:0] REG_ONE_HIGH   = 3'd3;
    localparam logic [2:0] REG_ONE_LOW    = 3'd4;
    localparam logic [2:0] REG_ZERO_HIGH  = 3'd5;
    localparam logic [2:0] REG_ZERO_LOW   = 3'd6;

    localparam logic [SLOT_W-1:0] RST_RED_SLOT   = 2'd1;
    localparam logic [SLOT_W-1:0] RST_GREEN_SLOT = 2'd0;
    localparam logic [SLOT_W-1:0] RST_BLUE_SLOT  = 2'd2;
    localparam logic [TICK_W-1:0] RST_ONE_HIGH   = 8'd8;
    localparam logic [TICK_W-1:0] RST_ONE_LOW    = 8'd4;
    localparam logic [TICK_W-1:0] RST_ZERO_HIGH  = 8'd4;
    localparam logic [TICK_W-1:0] RST_ZERO_LOW   = 8'd8;

    typedef struct packed {
        logic [SLOT_W-1:0] red_slot;
        logic [SLOT_W-1:0] green_slot;
        logic [SLOT_W-1:0] blue_slot;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
    } t_cfg;

    // exact floor(p/255) for any product of two bytes (p up to 255*255): (p + (p >> 8) + 1) >> 8
    function automatic logic [BYTE_W-1:0] div255(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] t;
        t = {1'b0, p} + {9'd0, p[PROD_W-1:BYTE_W]} + {{PROD_W{1'b0}}, 1'b1};
        return t[PROD_W-1:BYTE_W];
    endfunction

endpackage

@@ hdl/rppe_if.sv @@
// ============================================================================
// rppe_if : pixel request and pulse descriptor channels
// Valid/ready channels; a request moves when valid and ready are both high.
// ============================================================================
interface rppe_pix_if import rppe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LED_W-1:0]  pixel_index;
    logic [BYTE_W-1:0] level;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;

    modport source (output valid, pixel_index, level, red, green, blue, input ready);
    modport sink   (input valid, pixel_index, level, red, green, blue, output ready);
endinterface

interface rppe_pulse_if import rppe_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [LED_W-1:0]    led_number;
    logic [BITNUM_W-1:0] bit_number;
    logic                bit_value;
    logic [TICK_W-1:0]   high_ticks;
    logic [TICK_W-1:0]   low_ticks;
    logic                last_bit;

    modport source (output valid, led_number, bit_number, bit_value, high_ticks,
                    low_ticks, last_bit, input ready);
    modport sink   (input valid, led_number, bit_number, bit_value, high_ticks,
                    low_ticks, last_bit, output ready);
endinterface

@@ hdl/rppe_scale_lane.sv @@
// ============================================================================
// rppe_scale_lane : one color channel scaler
// Registers value*level, then divides the product by 255 with truncation.
// ============================================================================
module rppe_scale_lane import rppe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [BYTE_W-1:0] i_value,
    input  logic [BYTE_W-1:0] i_level,
    output logic [BYTE_W-1:0] o_scaled
);

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_value) * PROD_W'(i_level);
        end
    end

    assign o_scaled = div255(r_prod);

endmodule

@@ hdl/rppe_merge.sv @@
// ============================================================================
// rppe_merge : byte slot placement
// Combines the three lane results into the 24-bit word by configured slots.
// ============================================================================
module rppe_merge import rppe_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  logic                      i_valid,
    input  logic [LED_W-1:0]          i_led,
    input  logic [BYTE_W-1:0]         i_red,
    input  logic [BYTE_W-1:0]         i_green,
    input  logic [BYTE_W-1:0]         i_blue,
    output logic                      o_ready,
    input  logic                      i_take,
    output logic                      o_valid,
    output logic [LED_W-1:0]          o_led,
    output logic [BITS_PER_PIXEL-1:0] o_word
);

    logic                      r_valid;
    logic [LED_W-1:0]          r_led;
    logic [BITS_PER_PIXEL-1:0] r_word;
    logic                      n_valid;
    logic [BITS_PER_PIXEL-1:0] n_word;

    // later writer wins: blue over green over red; unclaimed slot is zero
    function automatic logic [BYTE_W-1:0] pick(input logic [SLOT_W-1:0] s,
                                               input t_cfg c,
                                               input logic [BYTE_W-1:0] r,
                                               input logic [BYTE_W-1:0] g,
                                               input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] v;
        v = '0;
        if (c.red_slot == s)   v = r;
        if (c.green_slot == s) v = g;
        if (c.blue_slot == s)  v = b;
        return v;
    endfunction

    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_word = {pick(SLOT_HI,  i_cfg, i_red, i_green, i_blue),
                  pick(SLOT_MID, i_cfg, i_red, i_green, i_blue),
                  pick(SLOT_LO,  i_cfg, i_red, i_green, i_blue)};
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
            r_led  <= i_led;
        end
    end

    assign o_valid = r_valid;
    assign o_led   = r_led;
    assign o_word  = r_word;

endmodule

@@ hdl/rppe_serializer.sv @@
// ============================================================================
// rppe_serializer : pulse descriptor sequencer
// Shifts the word out MSB first, one descriptor per accepted output.
// ============================================================================
module rppe_serializer import rppe_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  logic                      i_valid,
    input  logic [LED_W-1:0]          i_led,
    input  logic [BITS_PER_PIXEL-1:0] i_word,
    output logic                      o_take,
    rppe_pulse_if.source              o_pulse
);

    logic                      r_busy;
    logic [BITS_PER_PIXEL-1:0] r_word;
    logic [LED_W-1:0]          r_led;
    logic [BITNUM_W-1:0]       r_cnt;
    logic                      w_fire;
    logic                      w_last;

    assign w_last = (r_cnt == LAST_BIT_NUM);
    assign w_fire = r_busy && o_pulse.ready;
    assign o_take = !r_busy || (w_fire && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_take) begin
            r_busy <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_word <= i_word;
            r_led  <= i_led;
            r_cnt  <= '0;
        end else if (w_fire) begin
            r_word <= {r_word[BITS_PER_PIXEL-2:0], 1'b0};
            r_cnt  <= r_cnt + BITNUM_W'(1);
        end
    end

    assign o_pulse.valid      = r_busy;
    assign o_pulse.led_number = r_led;
    assign o_pulse.bit_number = r_cnt;
    assign o_pulse.bit_value  = r_word[BITS_PER_PIXEL-1];
    assign o_pulse.high_ticks = r_word[BITS_PER_PIXEL-1] ? i_cfg.one_high : i_cfg.zero_high;
    assign o_pulse.low_ticks  = r_word[BITS_PER_PIXEL-1] ? i_cfg.one_low : i_cfg.zero_low;
    assign o_pulse.last_bit   = w_last;

endmodule

@@ hdl/rgb_pixel_pulse_encoder.sv @@
// ============================================================================
// rgb_pixel_pulse_encoder : RGB pixel to LED pulse descriptor encoder
// Scales a pixel by brightness, orders its bytes and emits 24 pulses.
// ============================================================================
//
//  channel   dir  handshake     carries
//  --------  ---  ------------  -------------------------------------------
//  i_pix     in   valid/ready   pixel_index, level, red, green, blue
//  o_pulse   out  valid/ready   led_number, bit_number, bit_value,
//                               high_ticks, low_ticks, last_bit
//  APB       in   psel/penable  register writes and reads, pready tied high
//
//  Each request yields 24 descriptors, one per cycle while o_pulse.ready is
//  high, so the output sequencer sets the sustained rate. The lane registers
//  load on the accepting edge, then the merge register and then the sequencer
//  registers load as each has room, and the first descriptor is on o_pulse
//  as soon as the sequencer registers hold the word.
//  A request can wait in the lane and merge stages while the sequencer is
//  still sending, and the next word loads on the edge that takes bit 23.
//  Reset (synchronous, active low) empties all stages and restores the
//  register defaults (GRB order, 8/4 and 4/8 ticks).
//
module rgb_pixel_pulse_encoder import rppe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rppe_pix_if.sink          i_pix,
    rppe_pulse_if.source      o_pulse,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // configuration registers
    t_cfg                      r_cfg;
    logic                      w_wr;
    logic [2:0]                w_idx;

    // lane stage control
    logic                      r_s1_valid;
    logic [LED_W-1:0]          r_s1_led;
    logic                      w_accept;
    logic                      w_s1_ready;

    logic [BYTE_W-1:0]         w_red_s;
    logic [BYTE_W-1:0]         w_green_s;
    logic [BYTE_W-1:0]         w_blue_s;

    logic                      w_mrg_ready;
    logic                      w_mrg_valid;
    logic [LED_W-1:0]          w_mrg_led;
    logic [BITS_PER_PIXEL-1:0] w_mrg_word;
    logic                      w_take;

    // ---------------- APB register file ----------------
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red_slot   <= RST_RED_SLOT;
            r_cfg.green_slot <= RST_GREEN_SLOT;
            r_cfg.blue_slot  <= RST_BLUE_SLOT;
            r_cfg.one_high   <= RST_ONE_HIGH;
            r_cfg.one_low    <= RST_ONE_LOW;
            r_cfg.zero_high  <= RST_ZERO_HIGH;
            r_cfg.zero_low   <= RST_ZERO_LOW;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RED_SLOT:   r_cfg.red_slot   <= pwdata[SLOT_W-1:0];
                REG_GREEN_SLOT: r_cfg.green_slot <= pwdata[SLOT_W-1:0];
                REG_BLUE_SLOT:  r_cfg.blue_slot  <= pwdata[SLOT_W-1:0];
                REG_ONE_HIGH:   r_cfg.one_high   <= pwdata[TICK_W-1:0];
                REG_ONE_LOW:    r_cfg.one_low    <= pwdata[TICK_W-1:0];
                REG_ZERO_HIGH:  r_cfg.zero_high  <= pwdata[TICK_W-1:0];
                REG_ZERO_LOW:   r_cfg.zero_low   <= pwdata[TICK_W-1:0];
                default: ;  // past the register list: dropped
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_RED_SLOT:   prdata = DATA_W'(r_cfg.red_slot);
            REG_GREEN_SLOT: prdata = DATA_W'(r_cfg.green_slot);
            REG_BLUE_SLOT:  prdata = DATA_W'(r_cfg.blue_slot);
            REG_ONE_HIGH:   prdata = DATA_W'(r_cfg.one_high);
            REG_ONE_LOW:    prdata = DATA_W'(r_cfg.one_low);
            REG_ZERO_HIGH:  prdata = DATA_W'(r_cfg.zero_high);
            REG_ZERO_LOW:   prdata = DATA_W'(r_cfg.zero_low);
            default:        prdata = '0;
        endcase
    end

    // ---------------- lane stage ----------------
    // The lanes hold value*level; this stage tracks the request's valid
    // and LED number alongside them.
    assign w_s1_ready  = !r_s1_valid || w_mrg_ready;
    assign i_pix.ready = w_s1_ready;
    assign w_accept    = i_pix.valid && w_s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_led <= i_pix.pixel_index;
        end
    end

    rppe_scale_lane u_lane_red (
        .i_clk    (i_clk),
        .i_en     (w_accept),
        .i_value  (i_pix.red),
        .i_level  (i_pix.level),
        .o_scaled (w_red_s)
    );

    rppe_scale_lane u_lane_green (
        .i_clk    (i_clk),
        .i_en     (w_accept),
        .i_value  (i_pix.green),
        .i_level  (i_pix.level),
        .o_scaled (w_green_s)
    );

    rppe_scale_lane u_lane_blue (
        .i_clk    (i_clk),
        .i_en     (w_accept),
        .i_value  (i_pix.blue),
        .i_level  (i_pix.level),
        .o_scaled (w_blue_s)
    );

    // ---------------- merge: slot placement ----------------
    rppe_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (r_s1_valid),
        .i_led   (r_s1_led),
        .i_red   (w_red_s),
        .i_green (w_green_s),
        .i_blue  (w_blue_s),
        .o_ready (w_mrg_ready),
        .i_take  (w_take),
        .o_valid (w_mrg_valid),
        .o_led   (w_mrg_led),
        .o_word  (w_mrg_word)
    );

    // ---------------- output sequencer ----------------
    rppe_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_mrg_valid),
        .i_led   (w_mrg_led),
        .i_word  (w_mrg_word),
        .o_take  (w_take),
        .o_pulse (o_pulse)
    );

endmodule

@@ hdl/rppe_checker.sv @@
// ============================================================================
// rppe_checker : port-level checks for the pixel pulse encoder
// Watches the pulse channel for sequence order and stall behavior.
// ============================================================================
`include "rgb_pixel_pulse_encoder_macros.svh"

module rppe_checker import rppe_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_ready,
    input  logic [LED_W-1:0]    i_led_number,
    input  logic [BITNUM_W-1:0] i_bit_number,
    input  logic                i_last_bit
);

    // a stalled descriptor holds
    `RPPE_ASSERT(a_stall_hold, i_clk, i_rst_n, i_valid && !i_ready |=> i_valid && $stable(i_bit_number) && $stable(i_led_number))
    // inside a pixel the next descriptor follows at once with the next number
    `RPPE_ASSERT(a_bit_step, i_clk, i_rst_n, i_valid && i_ready && !i_last_bit |=> i_valid && (i_bit_number == $past(i_bit_number) + BITNUM_W'(1)))
    // a pixel keeps its LED number across its descriptors
    `RPPE_ASSERT_MSG(a_led_keep, i_clk, i_rst_n, i_valid && i_ready && !i_last_bit |=> $stable(i_led_number), "led number changed inside a pixel")
    // the last mark sits exactly on the final bit position
    `RPPE_ASSERT(a_last_pos, i_clk, i_rst_n, i_valid |-> (i_last_bit == (i_bit_number == LAST_BIT_NUM)))

endmodule

bind rgb_pixel_pulse_encoder rppe_checker u_rppe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_pulse.valid),
    .i_ready      (o_pulse.ready),
    .i_led_number (o_pulse.led_number),
    .i_bit_number (o_pulse.bit_number),
    .i_last_bit   (o_pulse.last_bit)
);
